### hdl/buis_pkg.sv
// Shared types, constants and the blend divider for the bilinear upscaler.
// No dependencies; front, back, top level and testbench use this package.
package buis_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_MAX_SCALE  = 4;

	localparam int COORD_W = 12;
	localparam int PIX_W   = 24;

	// Configuration register indexes.
	localparam logic [1:0] REG_SCALE  = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	localparam logic [2:0]  RST_SCALE  = 3'd2;
	localparam logic [10:0] RST_WIDTH  = 11'd640;
	localparam logic [10:0] RST_HEIGHT = 11'd480;

	localparam logic [7:0] WHITE = 8'hFF;

	// Fixed-point reciprocal of nine, scaled by 2^16.
	localparam logic [12:0] RECIP_NINE = 13'd7282;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_INNER,
		BK_WHITE
	} back_st_t;

	// One unit of work handed from the front to the back.
	typedef struct packed {
		logic [PIX_W-1:0]   ul;
		logic [PIX_W-1:0]   above;
		logic [PIX_W-1:0]   cur;
		logic [PIX_W-1:0]   left;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic               inner;
		logic               white;
	} job_t;

	// One finished result pixel.
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic               last;
	} res_t;

	// Divide a weighted sum by the square of the scale (1, 4, 9 or 16).
	function automatic logic [7:0] div_sq(input logic [11:0] acc, input logic [2:0] s);
		logic [24:0] prod;
		logic [7:0]  q;
		prod = {13'd0, acc} * {12'd0, RECIP_NINE};
		unique case (s)
			3'd2:    q = acc[9:2];
			3'd3:    q = prod[23:16];
			3'd4:    q = acc[11:4];
			default: q = acc[7:0];
		endcase
		return q;
	endfunction

endpackage

### hdl/buis_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module buis_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

### hdl/buis_queue.sv
// Small first-in first-out queue of flat words, used between the stages.
// No dependencies.
module buis_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           din,
	input  logic                       pop,
	output logic [WIDTH-1:0]           dout,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [WIDTH-1:0]           mem_q [DEPTH];
	logic [PW-1:0]              wptr_q, rptr_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic                       do_push, do_pop;

	assign full    = (cnt_q == ($clog2(DEPTH+1))'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign dout    = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hdl/buis_front.sv
// Front end: accepts source pixels, tracks the raster position, keeps the
// line store and neighbour pixels, and builds jobs. Uses buis_pkg, buis_ram.
module buis_front #(
	parameter int MAX_WIDTH  = buis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = buis_pkg::DEF_MAX_HEIGHT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              restart,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]    width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]   height,
	input  logic                              push,
	input  logic [buis_pkg::PIX_W-1:0]        pix,
	output logic                              full,
	output logic                              job_push,
	output buis_pkg::job_t                    job,
	input  logic                              job_full
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int HW = $clog2(MAX_HEIGHT+1);

	logic [CW-1:0]               col_q, col_s1;
	logic [RW-1:0]               row_q, row_s1;
	logic [WW-1:0]               col_nx;
	logic [HW-1:0]               row_nx;
	logic                        v_s1_q;
	logic [buis_pkg::PIX_W-1:0]  pix_s1, ul_q, left_q, above;
	logic                        accept, fire;

	assign full   = v_s1_q && job_full;
	assign accept = push && !full;
	assign fire   = v_s1_q && !job_full;
	assign col_nx = WW'(col_q) + 1'b1;
	assign row_nx = HW'(row_q) + 1'b1;

	// The pixel above is read when the pixel arrives, written back when it leaves.
	buis_ram #(
		.WIDTH (buis_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.we      (fire),
		.waddr   (col_s1),
		.wdata   (pix_s1),
		.re      (accept),
		.raddr   (col_q),
		.rdata_q (above)
	);

	// Raster position of the next pixel and the stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			v_s1_q <= 1'b0;
		end else begin
			v_s1_q <= accept || (v_s1_q && job_full);
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (col_nx >= width) begin
					col_q <= '0;
					row_q <= (row_nx >= height) ? '0 : RW'(row_nx);
				end else begin
					col_q <= CW'(col_nx);
				end
			end
		end
	end

	// Pixel and position of the pixel being classified.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pix;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

	// Neighbour pixels shift along as each pixel leaves the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q   <= '0;
			left_q <= '0;
		end else if (fire) begin
			ul_q   <= above;
			left_q <= pix_s1;
		end
	end

	// Classify the pixel: interior cell ends here, border cell is white, else no job.
	always_comb begin
		job.ul    = ul_q;
		job.above = above;
		job.cur   = pix_s1;
		job.left  = left_q;
		job.row   = buis_pkg::COORD_W'(row_s1);
		job.col   = buis_pkg::COORD_W'(col_s1);
		job.inner = (row_s1 != '0) && (col_s1 != '0);
		job.white = (HW'(row_s1) == height - 1'b1) || (WW'(col_s1) == width - 1'b1);
		job_push  = fire && (job.inner || job.white);
	end

endmodule

### hdl/buis_back.sv
// Back end: walks the output blocks of each job, blends the four neighbours
// in a short pipeline and feeds the result queue. Uses buis_pkg.
module buis_back #(
	parameter int OUT_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [2:0]                     scale,
	input  buis_pkg::job_t                 job,
	input  logic                           job_valid,
	output logic                           job_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
	output logic                           res_push,
	output buis_pkg::res_t                 res
);

	localparam int OCW = $clog2(OUT_DEPTH+1);

	buis_pkg::back_st_t st_q, st_d;
	logic [1:0]  dx_q, dy_q, dx_d, dy_d;
	logic        issue, credit, blk_end, white_ph;
	logic [2:0]  sx, sy;
	logic [5:0]  p1, p2, p3, p4;
	logic [buis_pkg::COORD_W-1:0] brow, bcol;
	logic [14:0] mrow, mcol;

	// Stage one: weights, coordinates and the four pixels.
	logic        v_s1, white_s1, last_s1;
	logic [4:0]  w1_s1, w2_s1, w3_s1, w4_s1;
	logic [buis_pkg::COORD_W-1:0] row_s1, col_s1;
	logic [buis_pkg::PIX_W-1:0]   c1_s1, c2_s1, c3_s1, c4_s1;
	logic [2:0]  s_s1;

	// Stage two: weighted sums per channel.
	logic        v_s2, white_s2, last_s2;
	logic [11:0] acc_s2 [3];
	logic [buis_pkg::COORD_W-1:0] row_s2, col_s2;
	logic [2:0]  s_s2;

	assign credit = (OCW'(out_count) + OCW'(v_s1) + OCW'(v_s2)) < OCW'(OUT_DEPTH);
	assign blk_end = (dx_q == 2'(scale - 3'd1)) && (dy_q == 2'(scale - 3'd1));

	// Block sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= buis_pkg::BK_IDLE;
			dx_q <= '0;
			dy_q <= '0;
		end else begin
			st_q <= st_d;
			dx_q <= dx_d;
			dy_q <= dy_d;
		end
	end

	// Block sequencer: next state, step of the block, job release.
	always_comb begin
		st_d    = st_q;
		dx_d    = dx_q;
		dy_d    = dy_q;
		issue   = 1'b0;
		job_pop = 1'b0;
		unique case (st_q)
			buis_pkg::BK_IDLE: begin
				dx_d = '0;
				dy_d = '0;
				if (job_valid) begin
					st_d = job.inner ? buis_pkg::BK_INNER : buis_pkg::BK_WHITE;
				end
			end
			buis_pkg::BK_INNER, buis_pkg::BK_WHITE: begin
				issue = credit;
				if (issue) begin
					if (blk_end) begin
						dx_d = '0;
						dy_d = '0;
						if (st_q == buis_pkg::BK_INNER && job.white) begin
							st_d = buis_pkg::BK_WHITE;
						end else begin
							st_d    = buis_pkg::BK_IDLE;
							job_pop = 1'b1;
						end
					end else if (dx_q == 2'(scale - 3'd1)) begin
						dx_d = '0;
						dy_d = dy_q + 1'b1;
					end else begin
						dx_d = dx_q + 1'b1;
					end
				end
			end
			default: begin
				st_d = buis_pkg::BK_IDLE;
			end
		endcase
	end

	// Weights of the four neighbours and the output coordinates.
	always_comb begin
		white_ph = (st_q == buis_pkg::BK_WHITE);
		sx   = scale - {1'b0, dx_q};
		sy   = scale - {1'b0, dy_q};
		p1   = {3'd0, sx} * {3'd0, sy};
		p2   = {4'd0, dx_q} * {3'd0, sy};
		p3   = {4'd0, dx_q} * {4'd0, dy_q};
		p4   = {3'd0, sx} * {4'd0, dy_q};
		brow = white_ph ? job.row : job.row - 1'b1;
		bcol = white_ph ? job.col : job.col - 1'b1;
		mrow = {3'd0, brow} * {12'd0, scale};
		mcol = {3'd0, bcol} * {12'd0, scale};
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			white_s1 <= white_ph;
			last_s1  <= job_pop;
			w1_s1    <= p1[4:0];
			w2_s1    <= p2[4:0];
			w3_s1    <= p3[4:0];
			w4_s1    <= p4[4:0];
			row_s1   <= mrow[11:0] + {10'd0, dy_q};
			col_s1   <= mcol[11:0] + {10'd0, dx_q};
			c1_s1    <= job.ul;
			c2_s1    <= job.above;
			c3_s1    <= job.cur;
			c4_s1    <= job.left;
			s_s1     <= scale;
		end
	end

	// Stage two: per-channel weighted sum of the neighbours.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int k = 0; k < 3; k++) begin
				acc_s2[k] <= 12'({5'd0, c1_s1[16-8*k +: 8]} * {8'd0, w1_s1})
				           + 12'({5'd0, c2_s1[16-8*k +: 8]} * {8'd0, w2_s1})
				           + 12'({5'd0, c3_s1[16-8*k +: 8]} * {8'd0, w3_s1})
				           + 12'({5'd0, c4_s1[16-8*k +: 8]} * {8'd0, w4_s1});
			end
			white_s2 <= white_s1;
			last_s2  <= last_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			s_s2     <= s_s1;
		end
	end

	// Normalise by the square of the scale, or force white on the border.
	always_comb begin
		res_push  = v_s2;
		res.row   = row_s2;
		res.col   = col_s2;
		res.last  = last_s2;
		res.red   = white_s2 ? buis_pkg::WHITE : buis_pkg::div_sq(acc_s2[0], s_s2);
		res.green = white_s2 ? buis_pkg::WHITE : buis_pkg::div_sq(acc_s2[1], s_s2);
		res.blue  = white_s2 ? buis_pkg::WHITE : buis_pkg::div_sq(acc_s2[2], s_s2);
	end

	// A job leaves the queue only on the final beat of its final block.
	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> issue && blk_end)
		else $error("job released before its last block finished");

	// The credit check must keep the result queue from overflowing.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> out_count < OCW'(OUT_DEPTH))
		else $error("result written into a full queue");

	// Work is only issued while a job is present.
	a_issue_job: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> job_valid)
		else $error("block step issued without a job");

	// An issued step is queued as a result after stage one and stage two.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> ##1 res_push)
		else $error("blend pipeline lost a beat");

endmodule

### hdl/bilinear_integer_upscaler_unit.sv
// Top level of the bilinear integer upscaler: configuration registers, front
// end, job queue, back end and result queue. Uses buis_pkg and all buis_ modules.
//
//  Channel   Direction  Handshake                Payload
//  pixels    in         push / full              pix_red, pix_green, pix_blue
//  results   out        empty / pop              out_row, out_col, res_*, run_last
//  config    in         wr_en (no wait)          wr_index, wr_data
//
// Each pixel is classified in the front stage; the back end then issues one
// result per cycle while the result queue has room, scale^2 or 2*scale^2 per job.
// The blend pipeline passes each result through its stage one and two registers.
// Reset clears the position counters, neighbour pixels and queues; the line
// store is not cleared. Either side may stall freely: a two-entry job queue
// and an eight-entry result queue decouple the front, back and consumer.
module bilinear_integer_upscaler_unit #(
	parameter int MAX_WIDTH  = buis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = buis_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_SCALE  = buis_pkg::DEF_MAX_SCALE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [10:0] wr_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  pix_red,
	input  logic [7:0]  pix_green,
	input  logic [7:0]  pix_blue,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] out_row,
	output logic [11:0] out_col,
	output logic [7:0]  res_red,
	output logic [7:0]  res_green,
	output logic [7:0]  res_blue,
	output logic        run_last
);

	localparam int WW       = $clog2(MAX_WIDTH+1);
	localparam int HW       = $clog2(MAX_HEIGHT+1);
	localparam int JQ_DEPTH = 2;
	localparam int RQ_DEPTH = 8;

	logic [2:0]     scale_q, scale_eff;
	logic [10:0]    width_q, height_q;
	logic [WW-1:0]  width_eff;
	logic [HW-1:0]  height_eff;
	logic           restart;

	buis_pkg::job_t job_in, job_out;
	logic           job_push, job_pop, job_full, job_empty;
	logic [$clog2(JQ_DEPTH+1)-1:0] job_cnt;

	buis_pkg::res_t res_in, res_out;
	logic           res_push, res_full;
	logic [$clog2(RQ_DEPTH+1)-1:0] res_cnt;

	// Configuration registers; any valid write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= buis_pkg::RST_SCALE;
			width_q  <= buis_pkg::RST_WIDTH;
			height_q <= buis_pkg::RST_HEIGHT;
		end else if (wr_en) begin
			unique case (wr_index)
				buis_pkg::REG_SCALE:  scale_q  <= wr_data[2:0];
				buis_pkg::REG_WIDTH:  width_q  <= wr_data;
				buis_pkg::REG_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign restart = wr_en && (wr_index == buis_pkg::REG_SCALE
		|| wr_index == buis_pkg::REG_WIDTH || wr_index == buis_pkg::REG_HEIGHT);

	// Register values held within their legal ranges.
	always_comb begin
		if (scale_q == 3'd0) begin
			scale_eff = 3'd1;
		end else if (int'(scale_q) > MAX_SCALE) begin
			scale_eff = 3'(MAX_SCALE);
		end else begin
			scale_eff = scale_q;
		end
		if (width_q < 11'd2) begin
			width_eff = WW'(2);
		end else if (int'(width_q) > MAX_WIDTH) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(width_q);
		end
		if (height_q < 11'd2) begin
			height_eff = HW'(2);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			height_eff = HW'(MAX_HEIGHT);
		end else begin
			height_eff = HW'(height_q);
		end
	end

	buis_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.width    (width_eff),
		.height   (height_eff),
		.push     (push),
		.pix      ({pix_red, pix_green, pix_blue}),
		.full     (full),
		.job_push (job_push),
		.job      (job_in),
		.job_full (job_full)
	);

	buis_queue #(
		.WIDTH ($bits(buis_pkg::job_t)),
		.DEPTH (JQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.pop    (job_pop),
		.dout   (job_out),
		.full   (job_full),
		.empty  (job_empty),
		.count  (job_cnt)
	);

	buis_back #(
		.OUT_DEPTH (RQ_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (scale_eff),
		.job       (job_out),
		.job_valid (!job_empty && job_cnt != '0),
		.job_pop   (job_pop),
		.out_count (res_cnt),
		.res_push  (res_push),
		.res       (res_in)
	);

	buis_queue #(
		.WIDTH ($bits(buis_pkg::res_t)),
		.DEPTH (RQ_DEPTH)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push && !res_full),
		.din    (res_in),
		.pop    (pop),
		.dout   (res_out),
		.full   (res_full),
		.empty  (empty),
		.count  (res_cnt)
	);

	assign out_row   = res_out.row;
	assign out_col   = res_out.col;
	assign res_red   = res_out.red;
	assign res_green = res_out.green;
	assign res_blue  = res_out.blue;
	assign run_last  = res_out.last;

endmodule

### test/tb_bilinear_integer_upscaler_unit.sv
// Self-checking testbench for bilinear_integer_upscaler_unit: predicts every result
// pixel from the accepted source pixels and checks them in order. Depends on buis_pkg.
module tb_bilinear_integer_upscaler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Scoreboard: holds the upscaler state and the queue of expected result pixels.
	class upscale_board;
		logic [23:0] line_mem [1024];
		logic [23:0] ul_pix, left_pix;
		int col_pos, row_pos;
		int scale, width, height;
		buis_pkg::res_t pending[$];
		int errors, pixels_in, results_out;

		function void clear_position();
			col_pos = 0;
			row_pos = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [10:0] val);
			if (idx == buis_pkg::REG_SCALE) begin
				scale = int'(val[2:0]);
			end else if (idx == buis_pkg::REG_WIDTH) begin
				width = int'(val);
			end else if (idx == buis_pkg::REG_HEIGHT) begin
				height = int'(val);
			end
			clear_position();
		endfunction

		function int blend(logic [7:0] c1, c2, c3, c4, int s, dx, dy);
			int acc;
			acc = int'(c1)*(s-dx)*(s-dy) + int'(c2)*dx*(s-dy) + int'(c3)*dx*dy
				+ int'(c4)*(s-dx)*dy;
			return acc / (s*s);
		endfunction

		// Note one accepted source pixel and queue the result pixels it causes.
		function void note_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
			int s, w, h, n;
			logic [23:0] cur, above;
			buis_pkg::res_t e;
			s = (scale == 0) ? 1 : (scale > 4 ? 4 : scale);
			w = (width < 2) ? 2 : (width > 1024 ? 1024 : width);
			h = (height < 2) ? 2 : (height > 1024 ? 1024 : height);
			cur = {rd, gr, bl};
			above = line_mem[col_pos];
			n = pending.size();
			pixels_in++;
			if (row_pos >= 1 && col_pos >= 1) begin
				for (int dy = 0; dy < s; dy++) begin
					for (int dx = 0; dx < s; dx++) begin
						e.row = 12'((row_pos-1)*s + dy);
						e.col = 12'((col_pos-1)*s + dx);
						e.red = 8'(blend(ul_pix[23:16], above[23:16], cur[23:16],
							left_pix[23:16], s, dx, dy));
						e.green = 8'(blend(ul_pix[15:8], above[15:8], cur[15:8],
							left_pix[15:8], s, dx, dy));
						e.blue = 8'(blend(ul_pix[7:0], above[7:0], cur[7:0],
							left_pix[7:0], s, dx, dy));
						e.last = 1'b0;
						pending.push_back(e);
					end
				end
			end
			if (row_pos == h-1 || col_pos == w-1) begin
				for (int dy = 0; dy < s; dy++) begin
					for (int dx = 0; dx < s; dx++) begin
						e.row = 12'(row_pos*s + dy);
						e.col = 12'(col_pos*s + dx);
						e.red = buis_pkg::WHITE;
						e.green = buis_pkg::WHITE;
						e.blue = buis_pkg::WHITE;
						e.last = 1'b0;
						pending.push_back(e);
					end
				end
			end
			if (pending.size() > n) pending[$].last = 1'b1;
			ul_pix = above;
			left_pix = cur;
			line_mem[col_pos] = cur;
			if (col_pos + 1 >= w) begin
				col_pos = 0;
				row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
			end else begin
				col_pos++;
			end
		endfunction

		// Compare one accepted result beat with the oldest expectation.
		function void check_result(buis_pkg::res_t got);
			buis_pkg::res_t e;
			results_out++;
			if (pending.size() == 0) begin
				$error("unexpected result row %0d col %0d", got.row, got.col);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.row !== e.row) begin
				$error("out_row: expected %0d, got %0d", e.row, got.row);
				errors++;
			end
			if (got.col !== e.col) begin
				$error("out_col: expected %0d, got %0d", e.col, got.col);
				errors++;
			end
			if (got.red !== e.red) begin
				$error("res_red: expected %0d, got %0d", e.red, got.red);
				errors++;
			end
			if (got.green !== e.green) begin
				$error("res_green: expected %0d, got %0d", e.green, got.green);
				errors++;
			end
			if (got.blue !== e.blue) begin
				$error("res_blue: expected %0d, got %0d", e.blue, got.blue);
				errors++;
			end
			if (got.last !== e.last) begin
				$error("run_last: expected %0d, got %0d", e.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [1:0] wr_index = buis_pkg::REG_SCALE;
	logic [10:0] wr_data = '0;
	logic push = 1'b0;
	logic full;
	logic [7:0] pix_red = '0, pix_green = '0, pix_blue = '0;
	logic empty;
	logic pop = 1'b0;
	logic [11:0] out_row, out_col;
	logic [7:0] res_red, res_green, res_blue;
	logic run_last;

	upscale_board board;
	bit quiet = 1'b0;         // no idling in the closing part of the run
	bit hold_off = 1'b0;      // request for a long receiver stall
	longint cycles = 0;
	localparam longint CYCLE_LIMIT = 2_000_000;

	bilinear_integer_upscaler_unit uut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_index(wr_index),
		.wr_data(wr_data), .push(push), .full(full), .pix_red(pix_red),
		.pix_green(pix_green), .pix_blue(pix_blue), .empty(empty), .pop(pop),
		.out_row(out_row), .out_col(out_col), .res_red(res_red),
		.res_green(res_green), .res_blue(res_blue), .run_last(run_last)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: pops with random stall bursts, plus one long hold-off on request.
	initial begin
		int gap;
		board = new();
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty)
				board.check_result('{out_row, out_col, res_red, res_green, res_blue,
					run_last});
			if (hold_off) begin
				pop <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
				pop <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				gap = $urandom_range(1, 16);
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				pop <= 1'b1;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Offer one pixel and wait until the block takes it; an idle burst may come first.
	task automatic send_pixel(logic [7:0] rd, logic [7:0] gr, logic [7:0] bl);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		push <= 1'b1;
		pix_red <= rd;
		pix_green <= gr;
		pix_blue <= bl;
		do @(posedge clk); while (full);
		board.note_pixel(rd, gr, bl);
	endtask

	task automatic send_random(int count);
		for (int k = 0; k < count; k++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Let the block drain: stop pushing and wait until no expected result is pending.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// One register write; the caller lowers the write enable after the last one.
	task automatic write_reg(logic [1:0] idx, logic [10:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		board.write_reg(idx, val);
	endtask

	task automatic set_frame(int s, int w, int h);
		drain();
		write_reg(buis_pkg::REG_SCALE, 11'(s));
		write_reg(buis_pkg::REG_WIDTH, 11'(w));
		write_reg(buis_pkg::REG_HEIGHT, 11'(h));
		wr_en <= 1'b0;
	endtask

	// Main sequence: directed corners first, then random frames of varied shape.
	initial begin
		int s, w, h;
		#1;
		wait (board != null);
		board.scale = int'(buis_pkg::RST_SCALE);
		board.width = int'(buis_pkg::RST_WIDTH);
		board.height = int'(buis_pkg::RST_HEIGHT);
		board.clear_position();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: 3x3 frame at scale 4 with extreme channel values.
		set_frame(4, 3, 3);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'hFF, 8'h00, 8'hFF);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'h55, 8'hAA, 8'h01);
		send_pixel(8'hAA, 8'h55, 8'h80);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h7F);
		send_pixel(8'h00, 8'hFF, 8'hFE);
		// Out-of-range settings: scale 0 and 7, width and height below 2.
		set_frame(0, 0, 1);
		send_random(4);
		set_frame(7, 2, 2);
		send_random(4);
		set_frame(3, 1, 3);
		send_random(6);

		// Long receiver stall while pixels keep coming.
		set_frame(4, 4, 4);
		hold_off = 1'b1;
		send_random(16);

		// Small random frames, then part of a row at the widest size and oversized ones.
		for (int f = 0; f < 17; f++) begin
			s = $urandom_range(1, 4);
			w = $urandom_range(2, 6);
			h = $urandom_range(2, 5);
			set_frame(s, w, h);
			send_random(w * h + $urandom_range(0, 3));
		end
		set_frame(1, 1024, 1024);
		send_random(60);
		set_frame(2, 2047, 2);
		send_random(8);
		set_frame(3, 5, 2047);
		send_random(12);

		// Closing part without any idling.
		quiet = 1'b1;
		set_frame(2, 5, 4);
		send_random(40);
		drain();

		$display("Ran %0d source pixels and checked %0d result pixels over %0d cycles.",
			board.pixels_in, board.results_out, cycles);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

### filelist.f
hdl/buis_pkg.sv
hdl/buis_ram.sv
hdl/buis_queue.sv
hdl/buis_front.sv
hdl/buis_back.sv
hdl/bilinear_integer_upscaler_unit.sv
test/tb_bilinear_integer_upscaler_unit.sv
